// File: sv/lcdns_pkg.sv
// lcdns_pkg: shared types and constants for the character lcd nibble sequencer
// no dependencies; imported by char_lcd_nibble_sequencer_top
`default_nettype none

package lcdns_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef logic [2:0] phase_t;
  typedef logic [3:0] step_t;
  typedef logic [2:0] reg_idx_t;
  typedef logic [7:0] byte_t;

  localparam phase_t PHASE_START = 3'd0;
  localparam phase_t PHASE_HIGH  = 3'd1;
  localparam phase_t PHASE_LOW   = 3'd2;
  localparam phase_t PHASE_FALL  = 3'd3;
  localparam phase_t PHASE_LAST  = 3'd4;
  localparam phase_t PHASE_IDLE  = 3'd5;

  localparam step_t STEP_WAIT     = 4'd0;
  localparam step_t STEP_LAST_CMD = 4'd9;
  localparam step_t STEP_DONE     = 4'd10;
  localparam step_t STEP_WAKE_END = 4'd3;

  localparam int NUM_REGS = 8;

  localparam reg_idx_t REG_WAKE       = 3'd0;
  localparam reg_idx_t REG_SECOND     = 3'd1;
  localparam reg_idx_t REG_LINES      = 3'd2;
  localparam reg_idx_t REG_FOURTH     = 3'd3;
  localparam reg_idx_t REG_FIFTH      = 3'd4;
  localparam reg_idx_t REG_SIXTH      = 3'd5;
  localparam reg_idx_t REG_SEVENTH    = 3'd6;
  localparam reg_idx_t REG_PHASE_WAIT = 3'd7;

  localparam byte_t REG_RESET [NUM_REGS] = '{
    8'd51, 8'd50, 8'd40, 8'd12, 8'd1, 8'd6, 8'd128, 8'd2
  };

endpackage

`default_nettype wire

// File: sv/char_lcd_nibble_sequencer_top.sv
// char_lcd_nibble_sequencer_top: 4-bit character lcd init and byte sequencer
// depends on lcdns_pkg
//
//  channel | direction | ports                                  | accepted when
//  in      | input     | in_opcode, in_byte_value               | in_valid & in_ready
//  out     | output    | out_pin_e .. out_busy_res              | out_valid & out_ready
//  cfg     | input     | cfg_index, cfg_data                    | cfg_valid & cfg_ready
//
// one word per cycle while out is not stalled; each word passes through the input
// register and then the result register
// the sequencer state updates in the cycle a word leaves the input register
// a stall on out holds the result register and then the input register
// cfg_ready is always high; reset sets the sequencer state and valid flags and loads REG_RESET into the register file
`default_nettype none

module char_lcd_nibble_sequencer_top #(
  parameter int FIRST_WAIT = 40
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [7:0]        in_byte_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_pin_e,
  output logic                   out_pin_rs,
  output logic                   out_pin_rw,
  output logic [3:0]             out_bus_nibble,
  output logic                   out_accepted,
  output logic                   out_xfer_done,
  output logic                   out_init_done,
  output logic                   out_busy_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire lcdns_pkg::reg_idx_t cfg_index,
  input  wire lcdns_pkg::byte_t    cfg_data
);
  import lcdns_pkg::*;

  localparam byte_t FIRST_WAIT_B = byte_t'(FIRST_WAIT);

  // register file
  byte_t regs_r [NUM_REGS];

  // input register
  logic    s1_valid_r;
  opcode_t s1_op_r;
  byte_t   s1_byte_r;

  // sequencer state
  step_t  step_r, step_nxt;
  phase_t phase_r, phase_nxt;
  byte_t  xbyte_r, xbyte_nxt;
  logic   is_data_r, is_data_nxt;
  byte_t  wait_r, wait_nxt;
  logic   e_r, e_nxt;
  logic   rs_r, rs_nxt;
  logic [3:0] nib_r, nib_nxt;

  logic   acc_nxt, done_nxt;
  logic   advance;
  byte_t  wait_dec;
  byte_t  init_cmd;
  step_t  step_inc;
  logic   init_done_w;
  byte_t  pw;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign pw        = regs_r[REG_PHASE_WAIT];
  assign init_done_w = (step_r >= STEP_DONE);
  assign step_inc  = step_r + 4'd1;
  assign wait_dec  = (wait_r != 8'd0) ? wait_r - 8'd1 : 8'd0;

  // command sent for the init step about to start
  always_comb begin
    if (step_inc <= STEP_WAKE_END) begin
      init_cmd = regs_r[REG_WAKE];
    end else begin
      init_cmd = regs_r[3'(step_inc - STEP_WAKE_END)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= REG_RESET[i];
    end else if (cfg_valid && cfg_ready) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= opcode_t'(in_opcode);
      s1_byte_r <= in_byte_value;
    end
  end

  always_comb begin
    step_nxt    = step_r;
    phase_nxt   = phase_r;
    xbyte_nxt   = xbyte_r;
    is_data_nxt = is_data_r;
    wait_nxt    = wait_r;
    e_nxt       = e_r;
    rs_nxt      = rs_r;
    nib_nxt     = nib_r;
    acc_nxt     = 1'b0;
    done_nxt    = 1'b0;
    if (advance) begin
      case (s1_op_r)
        OP_TICK: begin
          wait_nxt = wait_dec;
          if (wait_dec == 8'd0) begin
            if (phase_r < PHASE_IDLE) begin
              case (phase_r)
                PHASE_HIGH: begin
                  nib_nxt   = xbyte_r[7:4];
                  e_nxt     = 1'b0;
                  phase_nxt = PHASE_LOW;
                  wait_nxt  = pw;
                end
                PHASE_LOW: begin
                  e_nxt     = 1'b1;
                  nib_nxt   = xbyte_r[3:0];
                  phase_nxt = PHASE_FALL;
                  wait_nxt  = pw;
                end
                PHASE_FALL: begin
                  e_nxt     = 1'b0;
                  phase_nxt = PHASE_LAST;
                  wait_nxt  = pw;
                end
                PHASE_LAST: begin
                  phase_nxt = PHASE_IDLE;
                  if (init_done_w) begin
                    done_nxt = 1'b1;
                  end else begin
                    wait_nxt = pw;
                  end
                end
                default: begin
                  phase_nxt = PHASE_HIGH;
                end
              endcase
            end else begin
              phase_nxt = PHASE_IDLE;
              if (step_r < STEP_LAST_CMD) begin
                // next init command, always sent as a command
                step_nxt    = step_inc;
                xbyte_nxt   = init_cmd;
                is_data_nxt = 1'b0;
                e_nxt       = 1'b1;
                rs_nxt      = 1'b0;
                phase_nxt   = PHASE_HIGH;
                wait_nxt    = pw;
              end else if (step_r == STEP_LAST_CMD) begin
                step_nxt = STEP_DONE;
              end
            end
          end
        end
        OP_CMD, OP_DATA: begin
          if (init_done_w && phase_r == PHASE_IDLE) begin
            xbyte_nxt   = s1_byte_r;
            is_data_nxt = (s1_op_r == OP_DATA);
            e_nxt       = 1'b1;
            rs_nxt      = (s1_op_r == OP_DATA);
            phase_nxt   = PHASE_HIGH;
            wait_nxt    = pw;
            acc_nxt     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_WAIT;
      phase_r   <= PHASE_IDLE;
      xbyte_r   <= 8'd0;
      is_data_r <= 1'b0;
      wait_r    <= FIRST_WAIT_B;
      e_r       <= 1'b0;
      rs_r      <= 1'b0;
      nib_r     <= 4'd0;
    end else begin
      step_r    <= step_nxt;
      phase_r   <= phase_nxt;
      xbyte_r   <= xbyte_nxt;
      is_data_r <= is_data_nxt;
      wait_r    <= wait_nxt;
      e_r       <= e_nxt;
      rs_r      <= rs_nxt;
      nib_r     <= nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pin_e      <= e_nxt;
      out_pin_rs     <= rs_nxt;
      out_pin_rw     <= 1'b0;
      out_bus_nibble <= nib_nxt;
      out_accepted   <= acc_nxt;
      out_xfer_done  <= done_nxt;
      out_init_done  <= (step_nxt >= STEP_DONE);
      out_busy_res   <= (step_nxt < STEP_DONE) || (phase_nxt != PHASE_IDLE);
    end
  end

  // a taken request always starts a transfer after init
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_busy_res && out_init_done)
    else $error("accepted word without busy transfer");

  // a finished transfer leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_xfer_done |-> !out_busy_res && out_init_done && !out_accepted)
    else $error("transfer done while still busy");

  // init never restarts without reset
  a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    init_done_w |=> init_done_w)
    else $error("init done dropped");

  // phase state only moves when a word is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(step_r) && $stable(wait_r))
    else $error("sequencer state moved without a word");

endmodule

`default_nettype wire
